FILE: src/sinbs_pkg.sv
// ----------------------------------------------------------------------------
// Sorted index search package
// Shared types and constants for the sorted key table with floor search.
// ----------------------------------------------------------------------------
package sinbs_pkg;

    localparam int ROW_W     = 16;
    localparam int KEY_WIDTH = 32;
    localparam logic [ROW_W-1:0] POS_LAST = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    localparam logic [1:0] REG_KEY_SIGNED = 2'd0;
    localparam logic [1:0] REG_FIRST_ROW  = 2'd1;
    localparam logic [1:0] REG_ROW_LIMIT  = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear;     // reset count and position
        logic load_chk;  // evaluate load window, advance position
        logic shift;     // one insertion shift step
        logic put;       // write new entry at hole
        logic srch_init; // set up bisection bounds
        logic srch_rd;   // issue memory read at mid
        logic srch_cmp;  // compare read entry, narrow bounds
        logic fin_rd;    // read entry at lo-1
        logic out_load;  // latch load result
        logic out_srch;  // latch search result
        logic out_zero;  // latch all-zero result
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic load_ok;   // load kept
        logic shift_go;  // hole must move down once more
        logic srch_more; // bisection not yet done
        logic hit;       // last compare found an equal key
    } sts_t;

endpackage

FILE: src/sinbs_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted index search controller
// Sequences clear, load insertion and bisection search steps.
// ----------------------------------------------------------------------------
module sinbs_ctrl
    import sinbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [1:0] in_op,
    input  logic       out_free,
    input  sts_t       sts,
    output logic       busy,
    output logic       out_set,
    output cmd_t       cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LCHK  = 9'b000000010,
        S_LRD   = 9'b000000100,
        S_LSH   = 9'b000001000,
        S_SRD   = 9'b000010000,
        S_SCMP  = 9'b000100000,
        S_FRD   = 9'b001000000,
        S_FOUT  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Step the sequence
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        out_set    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_op)
                        OP_CLEAR:
                        begin
                            cmd.clear    = 1'b1;
                            cmd.out_zero = 1'b1;
                            state_next   = S_OUT;
                        end
                        OP_LOAD:
                        begin
                            cmd.load_chk = 1'b1;
                            state_next   = S_LCHK;
                        end
                        OP_SEARCH:
                        begin
                            cmd.srch_init = 1'b1;
                            state_next    = S_SRD;
                        end
                        default:
                        begin
                            cmd.out_zero = 1'b1;
                            state_next   = S_OUT;
                        end
                    endcase
                end
            end
            S_LCHK:
            begin
                cmd.out_load = 1'b1;
                state_next   = sts.load_ok ? S_LRD : S_OUT;
            end
            S_LRD:
            begin
                // read entry below the hole
                if (sts.shift_go)
                begin
                    cmd.shift  = 1'b1;
                    state_next = S_LSH;
                end
                else
                begin
                    cmd.put    = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_LSH:
            begin
                state_next = S_LRD;
            end
            S_SRD:
            begin
                if (sts.srch_more)
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_SCMP;
                end
                else
                begin
                    cmd.fin_rd = 1'b1;
                    state_next = S_FRD;
                end
            end
            S_SCMP:
            begin
                cmd.srch_cmp = 1'b1;
                state_next   = S_SRD;
                if (sts.hit)
                    state_next = S_FOUT;
            end
            S_FRD:
            begin
                state_next = S_FOUT;
            end
            S_FOUT:
            begin
                cmd.out_srch = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_set    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: src/sinbs_dp.sv
// ----------------------------------------------------------------------------
// Sorted index search datapath
// Key and row memories, counters, window checks and bisection bounds.
// ----------------------------------------------------------------------------
module sinbs_dp
    import sinbs_pkg::*;
#(
    parameter int MAX_ROWS  = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    input  logic                 in_fire,
    input  logic [KEY_WIDTH-1:0] in_key,
    input  logic                 key_signed,
    input  logic [15:0]          first_row,
    input  logic [8:0]           row_limit,
    output sts_t                 sts,
    output logic                 res_status,
    output logic                 res_found,
    output logic                 res_below,
    output logic [ROW_W-1:0]     res_row
);

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 2);

    logic [KEY_WIDTH-1:0] key_mem [MAX_ROWS];
    logic [ROW_W-1:0]     row_mem [MAX_ROWS];

    logic [CW-1:0]        count_reg;
    logic [ROW_W-1:0]     pos_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [ROW_W-1:0]     lpos_reg;
    logic                 ok_reg;
    logic [CW-1:0]        hole_reg;
    logic [CW-1:0]        lo_reg, hi_reg;
    logic [KEY_WIDTH-1:0] rd_key_reg;
    logic [ROW_W-1:0]     rd_row_reg;
    logic                 hit_reg;
    logic [ROW_W-1:0]     hit_row_reg;
    logic [AW-1:0]        rd_addr;
    logic                 rd_en;

    logic [KEY_WIDTH-1:0] sign_bit;
    assign sign_bit = {key_signed, {(KEY_WIDTH-1){1'b0}}};

    // Window check for the incoming load
    logic [ROW_W:0]   limit_w;
    logic [ROW_W:0]   off_w;
    logic             win_ok;
    always_comb
    begin
        limit_w = ((row_limit == '0) || (32'(row_limit) > MAX_ROWS))
                  ? (ROW_W+1)'(MAX_ROWS) : (ROW_W+1)'(row_limit);
        off_w   = {1'b0, pos_reg} - {1'b0, first_row};
        win_ok  = (pos_reg >= first_row) && (off_w < limit_w)
                  && (32'(count_reg) < MAX_ROWS);
    end

    // Mid point and compares
    logic [CW:0]          sum_w;
    logic [CW-1:0]        mid;
    logic [KEY_WIDTH-1:0] ov, oe;
    assign sum_w = {1'b0, hi_reg} + {1'b0, lo_reg};
    assign mid   = sum_w[CW:1];
    assign ov    = key_reg ^ sign_bit;
    assign oe    = rd_key_reg ^ sign_bit;

    // Shift decision: entry below hole moves up when it sorts after new key
    logic shift_go;
    assign shift_go = (hole_reg != '0) &&
                      ((oe > ov) || ((oe == ov) && (rd_row_reg > lpos_reg)));

    assign sts.load_ok   = ok_reg;
    assign sts.shift_go  = shift_go;
    assign sts.srch_more = (hi_reg - lo_reg) > CW'(1);
    assign sts.hit       = (ov == oe);

    // Memory read address
    logic [CW-1:0] hm1, mm1, lm1;
    assign hm1 = hole_reg - CW'(1);
    assign mm1 = mid - CW'(1);
    assign lm1 = lo_reg - CW'(1);
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (cmd.load_chk || cmd.shift)
        begin
            rd_en   = 1'b1;
            rd_addr = cmd.load_chk ? count_reg[AW-1:0] - AW'(1) : hm1[AW-1:0] - AW'(1);
        end
        else if (cmd.srch_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = mm1[AW-1:0];
        end
        else if (cmd.fin_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = lm1[AW-1:0];
        end
    end

    // Memories: registered read, one write; a shift moves the entry below
    // the hole up into the hole
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_row_reg <= row_mem[rd_addr];
        end
        if (cmd.shift)
        begin
            key_mem[hole_reg[AW-1:0]] <= rd_key_reg;
            row_mem[hole_reg[AW-1:0]] <= rd_row_reg;
        end
        else if (cmd.put)
        begin
            key_mem[hole_reg[AW-1:0]] <= key_reg;
            row_mem[hole_reg[AW-1:0]] <= lpos_reg;
        end
    end

    // Payload and bounds
    always_ff @(posedge clk)
    begin
        if (in_fire)
            key_reg <= in_key;
        if (cmd.load_chk)
        begin
            lpos_reg <= pos_reg;
            hole_reg <= count_reg;
        end
        if (cmd.shift)
            hole_reg <= hm1;
        if (cmd.srch_init)
        begin
            lo_reg  <= '0;
            hi_reg  <= count_reg + CW'(1);
            hit_reg <= 1'b0;
        end
        if (cmd.srch_cmp)
        begin
            if (ov == oe)
            begin
                hit_reg     <= 1'b1;
                hit_row_reg <= rd_row_reg;
            end
            else if (ov < oe)
                hi_reg <= mid;
            else
                lo_reg <= mid;
        end
    end

    // Count, position and load verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
                pos_reg   <= '0;
            end
            else if (cmd.load_chk)
            begin
                ok_reg <= (pos_reg != POS_LAST) && win_ok;
                if (pos_reg != POS_LAST)
                    pos_reg <= pos_reg + ROW_W'(1);
            end
            if (cmd.put)
                count_reg <= count_reg + CW'(1);
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_zero)
        begin
            res_status <= 1'b0;
            res_found  <= 1'b0;
            res_below  <= 1'b0;
            res_row    <= '0;
        end
        else if (cmd.out_load)
        begin
            res_status <= !ok_reg;
            res_found  <= 1'b0;
            res_below  <= 1'b0;
            res_row    <= '0;
        end
        else if (cmd.out_srch)
        begin
            res_status <= 1'b0;
            res_found  <= hit_reg;
            res_below  <= !hit_reg && (lo_reg == '0);
            res_row    <= hit_reg ? hit_row_reg :
                          ((lo_reg == '0) ? '0 : rd_row_reg);
        end
    end

endmodule

FILE: src/sorted_index_nearest_below_search.sv
// ----------------------------------------------------------------------------
// Sorted index nearest-below search
// Sorted key table with clear, load-insert and floor search requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_axis (tdata = op, key). One result per request
//   leaves on m_axis (tdata = status, found, below_all, row_index).
//   Configuration is written via cfg_we/cfg_index/cfg_data while idle.
//   One request is worked at a time; s_axis_tready is low while busy.
//   A load is dropped or else placed by an insertion walk that moves
//   entries through the key/row memory, which has one read and one
//   write port. A search runs bisection steps and ends early on an
//   exact hit; at most ceil(log2(count+1)) steps.
//   Reset empties the table and restores register defaults; memory
//   contents are left unknown and never used before written.
//   A stalled receiver holds the result in the output register; the next
//   request is still taken and worked, and its result waits until the
//   output register is free.
// ----------------------------------------------------------------------------
module sorted_index_nearest_below_search
    import sinbs_pkg::*;
#(
    parameter int MAX_ROWS  = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [1:0] op, [33:2] key, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [0] status, [1] found, [2] below_all,
                                        // [18:3] row_index, rest zero
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic        key_signed_reg;
    logic [15:0] first_row_reg;
    logic [8:0]  row_limit_reg;
    logic        tvalid_reg;
    logic [23:0] tdata_reg;
    logic        busy, out_set, in_fire;
    cmd_t        cmd;
    sts_t        sts;
    logic        r_status, r_found, r_below;
    logic [15:0] r_row;

    assign s_axis_tready = !busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_signed_reg <= 1'b1;
            first_row_reg  <= '0;
            row_limit_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_SIGNED: key_signed_reg <= cfg_data[0];
                REG_FIRST_ROW:  first_row_reg  <= cfg_data;
                REG_ROW_LIMIT:  row_limit_reg  <= cfg_data[8:0];
                default:        ;
            endcase
        end
    end

    sinbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_op    (s_axis_tdata[1:0]),
        .out_free (!tvalid_reg),
        .sts      (sts),
        .busy     (busy),
        .out_set  (out_set),
        .cmd      (cmd)
    );

    sinbs_dp #(
        .MAX_ROWS  (MAX_ROWS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_fire    (in_fire),
        .in_key     (s_axis_tdata[KEY_WIDTH+1:2]),
        .key_signed (key_signed_reg),
        .first_row  (first_row_reg),
        .row_limit  (row_limit_reg),
        .sts        (sts),
        .res_status (r_status),
        .res_found  (r_found),
        .res_below  (r_below),
        .res_row    (r_row)
    );

    // Output register: load when result posted, drop valid when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg <= 1'b0;
            tdata_reg  <= '0;
        end
        else if (out_set)
        begin
            tvalid_reg <= 1'b1;
            tdata_reg  <= {5'd0, r_row, r_below, r_found, r_status};
        end
        else if (m_axis_tready)
            tvalid_reg <= 1'b0;
    end

    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;

endmodule

FILE: src/sinbs_chk.sv
// ----------------------------------------------------------------------------
// Sorted index search port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module sinbs_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // A held result stays stable
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // One request at a time: ready drops after each accepted request
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while busy");

    // found and below_all never both set
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[2]))
        else $error("found and below_all both set");

    // below_all carries row zero
    a_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[18:3] == 16'd0)
        else $error("below_all with nonzero row");

endmodule

bind sorted_index_nearest_below_search sinbs_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
